// ----- hw/rtl/blset_pkg.sv -----
// Shared types and constants for the bounded list set.
package blset_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 8;
  localparam int FUNC_W       = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd2;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// ----- hw/rtl/blset_engine.sv -----
// Sequencer and entry memory: append, scan and shift-down removal.
module blset_engine
  import blset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [FUNC_W-1:0]    req_func,
  input  logic [VALUE_W-1:0]   req_value,
  output logic                 res_valid,
  input  logic                 res_take,
  output res_t                 res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_SHRD, S_SHWR, S_DONE
  } state_t;

  state_t             state_r;
  logic [FUNC_W-1:0]  func_r;
  logic [VALUE_W-1:0] value_r;
  logic [AW-1:0]      idx_r;
  logic [CW-1:0]      fill_r;
  logic               ok_r;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [CW-1:0]      idx_ext;
  logic               accept;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.ok    = ok_r;
  assign res.count = COUNT_W'(fill_r);
  assign idx_ext   = CW'(idx_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = fill_r[AW-1:0];
    wr_data = req_value;
    unique case (state_r)
      S_IDLE: begin
        wr_en = accept && (req_func == FUNC_ADD) && (fill_r < CAP_C);
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_SHRD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r + AW'(1);
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ok_r    <= 1'b0;
      idx_r   <= '0;
      func_r  <= FUNC_ADD;
      value_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r  <= req_func;
            value_r <= req_value;
            idx_r   <= '0;
            ok_r    <= 1'b0;
            state_r <= S_DONE;
            priority if (req_func == FUNC_ADD) begin
              if (fill_r < CAP_C) begin
                fill_r <= fill_r + CW'(1);
                ok_r   <= 1'b1;
              end
            end else if (req_func == FUNC_REMOVE || req_func == FUNC_CONTAINS) begin
              if (fill_r != '0) begin
                state_r <= S_RD;
              end
            end else begin
            end
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (rd_data_r == value_r) begin
            if (func_r == FUNC_CONTAINS) begin
              ok_r    <= 1'b1;
              state_r <= S_DONE;
            end else if (idx_ext + CW'(1) < fill_r) begin
              state_r <= S_SHRD;
            end else begin
              fill_r  <= fill_r - CW'(1);
              ok_r    <= 1'b1;
              state_r <= S_DONE;
            end
          end else if (idx_ext + CW'(1) < fill_r) begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SHRD: begin
          state_r <= S_SHWR;
        end
        S_SHWR: begin
          if (idx_ext + CW'(2) < fill_r) begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SHRD;
          end else begin
            fill_r  <= fill_r - CW'(1);
            ok_r    <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bounded_list_set_top.sv -----
// Top level of the bounded list set: sequencer and output register.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | in_valid in_ready in_func      | in
//           | in_value                       |
//   result  | out_valid out_ready out_ok     | out
//           | out_count                      |
//
// Add goes from acceptance straight to its result. Contains and remove
// read each scanned entry through the single memory read port and compare
// it; remove then shifts each later entry down with a read and a write.
// Reset clears the fill count; entries need no clearing pass.
// A result held in the output register does not stall the next request.
module bounded_list_set_top
  import blset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [COUNT_W-1:0]        out_count
);

  logic res_valid;
  logic res_take;
  res_t res;
  logic out_valid_r;
  res_t out_res_r;

  blset_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_func  (in_func),
    .req_value (in_value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_res_r.ok;
  assign out_count = out_res_r.count;

endmodule

// ----- sim/bounded_list_set_top_tb.sv -----
// Self-checking testbench for the bounded list set: directed and random requests.
`timescale 1ns / 100ps

module bounded_list_set_top_tb;
  import blset_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] held[$];
    res_t               owed[$];
    int                 failures;
    int                 n_func[4];
    int                 n_full;
    int                 n_miss;
    int                 n_hit;
    int                 peak;

    function int find_first(logic [VALUE_W-1:0] value);
      foreach (held[i])
        if (held[i] == value) return i;
      return -1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
      res_t exp;
      int   pos;
      exp.ok = 1'b0;
      n_func[func]++;
      case (func)
        FUNC_ADD: begin
          if (held.size() < DEPTH) begin
            held.push_back(value);
            exp.ok = 1'b1;
          end else begin
            n_full++;
          end
        end
        FUNC_REMOVE: begin
          pos = find_first(value);
          if (pos >= 0) begin
            held.delete(pos);
            exp.ok = 1'b1;
          end else begin
            n_miss++;
          end
        end
        FUNC_CONTAINS: begin
          exp.ok = (find_first(value) >= 0);
          if (exp.ok) n_hit++;
        end
        default: exp.ok = 1'b0;
      endcase
      exp.count = COUNT_W'(held.size());
      if (held.size() > peak) peak = held.size();
      owed.push_back(exp);
    endfunction

    function void check_result(logic ok, logic [COUNT_W-1:0] count);
      res_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result ok=%0b count=%0d", $time, ok, count);
        failures++;
        return;
      end
      exp = owed.pop_front();
      if (ok !== exp.ok) begin
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, exp.ok, ok);
        failures++;
      end
      if (count !== exp.count) begin
        $display("%0t: count mismatch: expected %0d, actual %0d", $time, exp.count, count);
        failures++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         in_func   = FUNC_ADD;
  logic signed [VALUE_W-1:0] in_value  = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_ok;
  logic [COUNT_W-1:0]        out_count;

  bit             quiet  = 1'b0;
  int             cycles = 0;
  list_scoreboard sb     = new();

  bounded_list_set_top #(.CAPACITY(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ok    (out_ok),
    .out_count (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** bounded_list_set_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_ok, out_count);
  end

  task automatic send_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 14);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(func, value);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(int from_list_pct);
    int r;
    r = $urandom_range(99);
    if (r < from_list_pct && sb.held.size() > 0)
      return sb.held[$urandom_range(sb.held.size() - 1)];
    if (r < from_list_pct + (100 - from_list_pct) / 2) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0000;
        default: return VALUE_W'($urandom_range(15));
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(phase_t phase, int n);
    int                 r;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      case (phase)
        PH_FILL:  func = (r < 88) ? FUNC_ADD : (r < 92) ? FUNC_REMOVE :
                         (r < 98) ? FUNC_CONTAINS : FUNC_UNUSED;
        PH_DRAIN: func = (r < 5) ? FUNC_ADD : (r < 90) ? FUNC_REMOVE :
                         (r < 98) ? FUNC_CONTAINS : FUNC_UNUSED;
        default:  func = (r < 35) ? FUNC_ADD : (r < 65) ? FUNC_REMOVE :
                         (r < 95) ? FUNC_CONTAINS : FUNC_UNUSED;
      endcase
      value = pick_value((phase == PH_DRAIN) ? 85 : 50);
      send_request(func, value);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FUNC_CONTAINS, 32'h0000_0000);
    send_request(FUNC_REMOVE,   32'h0000_0005);
    send_request(FUNC_UNUSED,   32'hFFFF_FFFF);
    send_request(FUNC_ADD,      32'h8000_0000);
    send_request(FUNC_ADD,      32'h7FFF_FFFF);
    send_request(FUNC_ADD,      32'h0000_0000);
    send_request(FUNC_ADD,      32'hFFFF_FFFF);
    send_request(FUNC_ADD,      32'h0000_0007);
    send_request(FUNC_ADD,      32'h0000_0007);
    send_request(FUNC_CONTAINS, 32'h8000_0000);
    send_request(FUNC_CONTAINS, 32'h7FFF_FFFF);
    send_request(FUNC_CONTAINS, 32'hAAAA_AAAA);
    send_request(FUNC_REMOVE,   32'h0000_0007);
    send_request(FUNC_CONTAINS, 32'h0000_0007);
    send_request(FUNC_REMOVE,   32'h0000_0007);
    send_request(FUNC_CONTAINS, 32'h0000_0007);
    send_request(FUNC_REMOVE,   32'h0000_0007);
    send_request(FUNC_UNUSED,   32'h8000_0000);
    send_request(FUNC_REMOVE,   32'h8000_0000);
    send_request(FUNC_REMOVE,   32'hFFFF_FFFF);
    send_request(FUNC_CONTAINS, 32'h0000_0000);
    send_request(FUNC_CONTAINS, 32'h7FFF_FFFF);

    run_phase(PH_FILL, 170);
    run_phase(PH_DRAIN, 200);
    run_phase(PH_MIXED, 60);
    quiet <= 1'b1;
    run_phase(PH_MIXED, 70);
    quiet <= 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d add, %0d remove, %0d contains and %0d unused-code requests",
             sb.n_func[FUNC_ADD], sb.n_func[FUNC_REMOVE], sb.n_func[FUNC_CONTAINS],
             sb.n_func[FUNC_UNUSED]);
    $display("Adds refused when full %0d, remove misses %0d, contains hits %0d, peak fill %0d",
             sb.n_full, sb.n_miss, sb.n_hit, sb.peak);
    if (sb.failures == 0) begin
      $display("** bounded_list_set_top: PASSED **");
    end else begin
      $display("** bounded_list_set_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- bounded_list_set_top.f -----
hw/rtl/blset_pkg.sv
hw/rtl/blset_engine.sv
hw/rtl/bounded_list_set_top.sv
sim/bounded_list_set_top_tb.sv
